// ----- rtl/core/blcs_pkg.sv -----
// Shared types, constants and codes of the broadcast level clamp and scale unit.
package blcs_pkg;

  localparam int SampleWidth = 8;
  localparam int CountWidth  = 17;
  localparam int IndexWidth  = 2;
  localparam int DataWidth   = 17;
  localparam int ProdWidth   = 2 * SampleWidth;
  localparam int SumWidth    = 10;

  typedef logic [SampleWidth-1:0]       sample_t;
  typedef logic signed [CountWidth-1:0] count_t;
  typedef logic [DataWidth-1:0]         cfg_data_t;
  typedef logic [ProdWidth-1:0]         prod_t;
  typedef logic signed [SumWidth-1:0]   level_sum_t;

  localparam sample_t FullScale     = 8'd255;
  localparam sample_t LowLevelInit  = 8'd16;
  localparam sample_t HighLevelInit = 8'd235;
  localparam count_t  CountLocked   = -17'sd1;

  typedef enum logic [1:0] {
    MODE_CLIP   = 2'd0,
    MODE_SCALE  = 2'd1,
    MODE_DETECT = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [IndexWidth-1:0] {
    REG_MODE        = 2'd0,
    REG_FRAME_COUNT = 2'd1,
    REG_LOW_LEVEL   = 2'd2,
    REG_HIGH_LEVEL  = 2'd3
  } reg_index_t;

  // Live settings handed from the control block to the sample lanes.
  typedef struct packed {
    mode_t   mode;
    sample_t low_level;
    sample_t high_level;
    sample_t span;      // |high_level - low_level|
    logic    span_neg;  // low_level lies above high_level
  } cfg_t;

  // Per-pixel selection that travels with the second stage.
  typedef struct packed {
    logic  active;
    mode_t mode;
  } lane_sel_t;

endpackage

// ----- rtl/core/blcs_ifs.sv -----
// Valid/ready channel interfaces for pixels in, pixels out and register writes.
interface blcs_pix_in_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  blcs_pkg::sample_t  luma_in;
  blcs_pkg::sample_t  blue_diff_in;
  blcs_pkg::sample_t  red_diff_in;

  modport source (output valid, frame_start, luma_in, blue_diff_in, red_diff_in,
                  input ready);
  modport sink (input valid, frame_start, luma_in, blue_diff_in, red_diff_in,
                output ready);
endinterface

interface blcs_pix_out_if;
  logic               valid;
  logic               ready;
  blcs_pkg::sample_t  luma_out;
  blcs_pkg::sample_t  blue_diff_out;
  blcs_pkg::sample_t  red_diff_out;
  logic               out_of_range;
  logic               filter_active;

  modport source (output valid, luma_out, blue_diff_out, red_diff_out, out_of_range,
                  filter_active, input ready);
  modport sink (input valid, luma_out, blue_diff_out, red_diff_out, out_of_range,
                filter_active, output ready);
endinterface

interface blcs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [blcs_pkg::IndexWidth-1:0] index;
  blcs_pkg::cfg_data_t         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/blcs_ctrl.sv -----
// Configuration registers and the frame countdown with its lock-on behavior.
module blcs_ctrl (
  input  logic              clk,
  input  logic              rst,
  blcs_cfg_if.sink          cfg,
  input  logic              step,
  input  logic              frame_start,
  input  logic              any_bad,
  output blcs_pkg::cfg_t    settings,
  output logic              active_now
);
  import blcs_pkg::*;

  mode_t   mode;
  sample_t low_level;
  sample_t high_level;
  count_t  frames_left;
  logic    frame_active;

  count_t  frames_left_next;
  count_t  frames_dec;
  logic    count_pos;
  logic    dec_pos;
  logic    lock;

  assign cfg.ready = 1'b1;

  always_comb begin
    count_pos  = !frames_left[CountWidth-1] && (frames_left != '0);
    active_now = frame_start ? (frames_left != '0) : frame_active;
    frames_dec = (frame_start && count_pos) ? frames_left - count_t'(1) : frames_left;
    dec_pos    = !frames_dec[CountWidth-1] && (frames_dec != '0);
    // A bad sample in clip or scale mode while the countdown runs locks the filter on.
    lock = active_now && any_bad && dec_pos &&
           (mode == MODE_CLIP || mode == MODE_SCALE);
    frames_left_next = lock ? CountLocked : frames_dec;
  end

  always_comb begin
    settings.mode       = mode;
    settings.low_level  = low_level;
    settings.high_level = high_level;
    settings.span_neg   = low_level > high_level;
    settings.span       = settings.span_neg ? low_level - high_level
                                            : high_level - low_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_CLIP;
      low_level    <= LowLevelInit;
      high_level   <= HighLevelInit;
      frames_left  <= CountLocked;
      frame_active <= 1'b0;
    end else begin
      if (step) begin
        frame_active <= active_now;
        frames_left  <= frames_left_next;
      end
      if (cfg.valid) begin
        unique case (reg_index_t'(cfg.index))
          REG_MODE:        mode        <= mode_t'(cfg.data[1:0]);
          REG_FRAME_COUNT: frames_left <= count_t'(cfg.data);
          REG_LOW_LEVEL:   low_level   <= cfg.data[SampleWidth-1:0];
          REG_HIGH_LEVEL:  high_level  <= cfg.data[SampleWidth-1:0];
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/blcs_lane.sv -----
// One sample lane: range check, clamp and scale product, then divide and select.
module blcs_lane (
  input  logic                 clk,
  input  logic                 load,
  input  blcs_pkg::sample_t    sample,
  input  blcs_pkg::cfg_t       settings,
  input  blcs_pkg::lane_sel_t  sel,
  output logic                 bad_now,
  output logic                 bad,
  output blcs_pkg::sample_t    result
);
  import blcs_pkg::*;

  sample_t    upper_clip;
  sample_t    clipped_next;
  prod_t      prod_next;

  sample_t    held;
  sample_t    clipped;
  prod_t      prod;

  logic [ProdWidth-1:0] quot_sum;
  sample_t    quot;
  level_sum_t scaled_wide;
  sample_t    scaled;

  // First stage: compare, clamp (high first, then low) and form v * |span|.
  always_comb begin
    bad_now      = (sample > settings.high_level) || (sample < settings.low_level);
    upper_clip   = (sample > settings.high_level) ? settings.high_level : sample;
    clipped_next = (upper_clip < settings.low_level) ? settings.low_level : upper_clip;
    prod_next    = prod_t'(sample) * prod_t'(settings.span);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held    <= sample;
      clipped <= clipped_next;
      prod    <= prod_next;
      bad     <= bad_now;
    end
  end

  // Second stage: floor(p / 255) as (p + (p >> 8) + 1) >> 8, exact for p up to 255 * 255.
  always_comb begin
    quot_sum    = prod + prod_t'(prod[ProdWidth-1:SampleWidth]) + prod_t'(1);
    quot        = quot_sum[ProdWidth-1:SampleWidth];
    scaled_wide = settings.span_neg
                  ? level_sum_t'(settings.low_level) - level_sum_t'(quot)
                  : level_sum_t'(settings.low_level) + level_sum_t'(quot);
    if (scaled_wide[SumWidth-1]) begin
      scaled = '0;
    end else if (scaled_wide[SumWidth-2]) begin
      scaled = FullScale;
    end else begin
      scaled = scaled_wide[SampleWidth-1:0];
    end

    if (!sel.active) begin
      result = held;
    end else begin
      unique case (sel.mode)
        MODE_CLIP:   result = clipped;
        MODE_SCALE:  result = bad ? scaled : held;
        MODE_DETECT: result = held;
        MODE_SPARE:  result = held;
      endcase
    end
  end

endmodule

// ----- rtl/core/broadcast_level_clamp_scale_unit.sv -----
// Top level of the broadcast level clamp and scale unit.
//
// Pixels arrive on pix_in, one Y/Cb/Cr triple per transfer with a frame_start
// mark on the first pixel of a frame. Processed pixels leave on pix_out with
// an out_of_range flag and a filter_active flag. Registers are written over
// cfg (0 mode, 1 frame_count, 2 low_level, 3 high_level); cfg is always ready
// and writes are expected only while the pipeline is empty.
//
// The datapath is a three-register pipeline: an input register, a middle
// register holding the clamp result and the scale product, and the output
// register. An accepted pixel passes through all three to reach pix_out.
// While the receiver keeps up, one pixel is taken every cycle, because each
// stage hands its pixel on in the same cycle that it takes the next one.
// The frame countdown advances as a pixel leaves the input register, so pixels
// see it strictly in order.
//
// Reset restores the default levels (16..235), clip mode, a countdown of -1
// (filter always on once a frame starts) and empties the pipeline. When the
// receiver stalls, each stage holds its pixel and ready falls back toward
// pix_in, so up to three pixels wait inside the block without loss.
module broadcast_level_clamp_scale_unit (
  input  logic          clk,
  input  logic          rst,
  blcs_pix_in_if.sink   pix_in,
  blcs_pix_out_if.source pix_out,
  blcs_cfg_if.sink      cfg
);
  import blcs_pkg::*;

  // Input register.
  logic      s1_valid;
  logic      s1_frame_start;
  sample_t   s1_luma;
  sample_t   s1_blue;
  sample_t   s1_red;

  // Middle stage control.
  logic      s2_valid;
  lane_sel_t s2_sel;

  logic      s1_adv;
  logic      s2_adv;
  logic      in_take;

  cfg_t      settings;
  logic      active_now;
  logic      bad_now_y;
  logic      bad_now_cb;
  logic      bad_now_cr;
  logic      bad_y;
  logic      bad_cb;
  logic      bad_cr;
  sample_t   res_y;
  sample_t   res_cb;
  sample_t   res_cr;
  logic      flag;

  // A stage moves on when the stage after it is empty or moving too.
  assign s2_adv        = s2_valid && (!pix_out.valid || pix_out.ready);
  assign s1_adv        = s1_valid && (!s2_valid || s2_adv);
  assign pix_in.ready  = !s1_valid || s1_adv;
  assign in_take       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_in.ready) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_frame_start <= pix_in.frame_start;
      s1_luma        <= pix_in.luma_in;
      s1_blue        <= pix_in.blue_diff_in;
      s1_red         <= pix_in.red_diff_in;
    end
  end

  blcs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (s1_adv),
    .frame_start (s1_frame_start),
    .any_bad     (bad_now_y || bad_now_cb || bad_now_cr),
    .settings    (settings),
    .active_now  (active_now)
  );

  blcs_lane u_lane_y (
    .clk      (clk),
    .load     (s1_adv),
    .sample   (s1_luma),
    .settings (settings),
    .sel      (s2_sel),
    .bad_now  (bad_now_y),
    .bad      (bad_y),
    .result   (res_y)
  );

  blcs_lane u_lane_cb (
    .clk      (clk),
    .load     (s1_adv),
    .sample   (s1_blue),
    .settings (settings),
    .sel      (s2_sel),
    .bad_now  (bad_now_cb),
    .bad      (bad_cb),
    .result   (res_cb)
  );

  blcs_lane u_lane_cr (
    .clk      (clk),
    .load     (s1_adv),
    .sample   (s1_red),
    .settings (settings),
    .sel      (s2_sel),
    .bad_now  (bad_now_cr),
    .bad      (bad_cr),
    .result   (res_cr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || s2_adv) begin
      s2_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_sel.active <= active_now;
      s2_sel.mode   <= settings.mode;
    end
  end

  // The spare mode code passes pixels untouched and never flags them.
  assign flag = s2_sel.active && (s2_sel.mode != MODE_SPARE) && (bad_y || bad_cb || bad_cr);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (!pix_out.valid || pix_out.ready) begin
      pix_out.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      pix_out.luma_out      <= res_y;
      pix_out.blue_diff_out <= res_cb;
      pix_out.red_diff_out  <= res_cr;
      pix_out.out_of_range  <= flag;
      pix_out.filter_active <= s2_sel.active;
    end
  end

endmodule

// ----- tb/sv/broadcast_level_clamp_scale_unit_test.sv -----
// Self-checking testbench of the broadcast level clamp and scale unit with a built-in predictor.
`timescale 1ns / 1ps

module broadcast_level_clamp_scale_unit_test;
  import blcs_pkg::*;

  // Run control. The watchdog limit sits far above the longest quiet
  // stretch the stimulus can create: the long receiver hold-off, a sender
  // gap, or the settling pause at the end.
  localparam int RandomPixels  = 450;
  localparam int HoldCycles    = 150;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 3000;
  localparam int MaxPrinted    = 100;
  localparam int NumRows       = 37;

  // One pixel as offered on the input channel.
  typedef struct packed {
    logic    frame_start;
    sample_t luma;
    sample_t blue_diff;
    sample_t red_diff;
  } pixel_t;

  // One pixel as it leaves the block, flags included.
  typedef struct packed {
    sample_t luma;
    sample_t blue_diff;
    sample_t red_diff;
    logic    out_of_range;
    logic    filter_active;
  } limited_pixel_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_t;

  // A row of the directed table is either a register write or a pixel.
  // Pixel rows with checked set carry the result read off by hand; the
  // others are checked against the predictor.
  typedef struct {
    row_kind_t      kind;
    reg_index_t     reg_sel;
    int             value;
    pixel_t         px;
    bit             checked;
    limited_pixel_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  blcs_pix_in_if  pix_in ();
  blcs_pix_out_if pix_out ();
  blcs_cfg_if     cfg ();

  broadcast_level_clamp_scale_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .cfg     (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers and of the frame state.
  mode_t   set_mode;
  sample_t level_low;
  sample_t level_high;
  count_t  frames_to_go;
  logic    frame_on;

  // Results still owed by the block, oldest first.
  limited_pixel_t expected_pixels [$];
  limited_pixel_t observed;
  limited_pixel_t predicted;
  int             errors;

  // Receiver hold-off requests: the sender raises the request count and the
  // receiver serves each request once with a long stall of its own.
  int hold_requests;

  // Directed table: reset levels first, then every mode, the frame
  // countdown, the lock, crossed levels and the extreme levels.
  stim_row_t directed_rows [NumRows] = '{
    // Before the first frame start the pixel passes untouched.
    '{ROW_PIXEL, REG_MODE, 0, '{0, 0, 255, 128}, 1, '{0, 255, 128, 0, 0}},
    // Clip with the reset levels 16..235 and the countdown at -1.
    '{ROW_PIXEL, REG_MODE, 0, '{1, 0, 0, 0}, 1, '{16, 16, 16, 1, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 255, 255, 255}, 1, '{235, 235, 235, 1, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 16, 235, 128}, 1, '{16, 235, 128, 0, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 15, 236, 17}, 0, '0},
    // Scale: the full-range extremes land exactly on the legal extremes.
    '{ROW_WRITE, REG_MODE, MODE_SCALE, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 0, 255, 128}, 1, '{16, 235, 128, 1, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 15, 236, 100}, 0, '0},
    // Detect only flags.
    '{ROW_WRITE, REG_MODE, MODE_DETECT, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 0, 255, 128}, 1, '{0, 255, 128, 1, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 16, 235, 128}, 1, '{16, 235, 128, 0, 1}},
    // The spare mode passes samples but still reports the frame state.
    '{ROW_WRITE, REG_MODE, MODE_SPARE, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 0, 255, 7}, 1, '{0, 255, 7, 0, 1}},
    // A countdown of zero passes whole frames through.
    '{ROW_WRITE, REG_MODE, MODE_CLIP, '0, 0, '0},
    '{ROW_WRITE, REG_FRAME_COUNT, 0, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 0, 255, 0}, 1, '{0, 255, 0, 0, 0}},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 1, 2, 3}, 1, '{1, 2, 3, 0, 0}},
    // Two clean frames use up the countdown, the third passes through.
    '{ROW_WRITE, REG_FRAME_COUNT, 2, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 100, 100, 100}, 1, '{100, 100, 100, 0, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 100, 100, 100}, 1, '{100, 100, 100, 0, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 0, 255, 0}, 1, '{0, 255, 0, 0, 0}},
    // An out-of-range sample during the countdown locks the filter on.
    '{ROW_WRITE, REG_FRAME_COUNT, 2, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 0, 128, 128}, 1, '{16, 128, 128, 1, 1}},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 50, 50, 50}, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 50, 50, 50}, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 255, 0, 0}, 1, '{235, 16, 16, 1, 1}},
    // Low level above high level, in clip and then in scale.
    '{ROW_WRITE, REG_LOW_LEVEL, 200, '0, 0, '0},
    '{ROW_WRITE, REG_HIGH_LEVEL, 50, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 100, 100, 100}, 0, '0},
    '{ROW_WRITE, REG_MODE, MODE_SCALE, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 0, 255, 100}, 0, '0},
    // Fully crossed levels give the most negative span.
    '{ROW_WRITE, REG_LOW_LEVEL, 255, '0, 0, '0},
    '{ROW_WRITE, REG_HIGH_LEVEL, 0, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{0, 255, 128, 0}, 0, '0},
    // Largest and negative countdown values.
    '{ROW_WRITE, REG_FRAME_COUNT, 65535, '0, 0, '0},
    '{ROW_PIXEL, REG_MODE, 0, '{1, 200, 10, 255}, 0, '0},
    '{ROW_WRITE, REG_FRAME_COUNT, -1, '0, 0, '0}
  };

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // A bad sample is flagged; during a positive countdown it also locks the
  // filter on for good.
  function automatic void note_violation(inout logic flag);
    flag = 1'b1;
    if (frames_to_go > 0) frames_to_go = CountLocked;
  endfunction

  // The test against the high level comes first, so with crossed levels
  // a sample above the high level ends at the low level.
  function automatic sample_t clip_sample(input sample_t v, inout logic flag);
    sample_t r;
    r = v;
    if (r > level_high) begin
      note_violation(flag);
      r = level_high;
    end
    if (r < level_low) begin
      note_violation(flag);
      r = level_low;
    end
    return r;
  endfunction

  // Only out-of-range samples are remapped. The product is signed and the
  // quotient truncates toward zero, then the sum saturates to 0..255.
  function automatic sample_t scale_sample(input sample_t v, inout logic flag);
    int r;
    if (v <= level_high && v >= level_low) return v;
    note_violation(flag);
    r = int'(v) * (int'(level_high) - int'(level_low)) / int'(FullScale)
        + int'(level_low);
    if (r < 0) r = 0;
    if (r > int'(FullScale)) r = int'(FullScale);
    return sample_t'(r);
  endfunction

  function automatic logic is_outside(input sample_t v);
    return (v > level_high) || (v < level_low);
  endfunction

  // Works out the result of one accepted pixel and advances the frame state.
  function automatic limited_pixel_t limit_pixel(input pixel_t px);
    limited_pixel_t res;
    logic           flag;
    flag = 1'b0;
    res  = '{px.luma, px.blue_diff, px.red_diff, 1'b0, 1'b0};
    if (px.frame_start) begin
      if (frames_to_go == 0) begin
        frame_on = 1'b0;
      end else begin
        frame_on = 1'b1;
        if (frames_to_go > 0) frames_to_go = frames_to_go - 17'sd1;
      end
    end
    if (frame_on) begin
      case (set_mode)
        MODE_CLIP: begin
          res.luma      = clip_sample(res.luma, flag);
          res.blue_diff = clip_sample(res.blue_diff, flag);
          res.red_diff  = clip_sample(res.red_diff, flag);
        end
        MODE_SCALE: begin
          res.luma      = scale_sample(res.luma, flag);
          res.blue_diff = scale_sample(res.blue_diff, flag);
          res.red_diff  = scale_sample(res.red_diff, flag);
        end
        MODE_DETECT: begin
          flag = is_outside(px.luma) || is_outside(px.blue_diff) ||
                 is_outside(px.red_diff);
        end
        default: begin
        end
      endcase
    end
    res.out_of_range  = flag;
    res.filter_active = frame_on;
    return res;
  endfunction

  // Mirrors a register write; the mode and level registers keep only the low bits of the word.
  function automatic void apply_register(input reg_index_t idx, input cfg_data_t word);
    case (idx)
      REG_MODE:        set_mode = mode_t'(word[1:0]);
      REG_FRAME_COUNT: begin
        frames_to_go = count_t'(word);
      end
      REG_LOW_LEVEL:   level_low = word[SampleWidth-1:0];
      default:         level_high = word[SampleWidth-1:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Reporting and channel tasks
  // ---------------------------------------------------------------------

  // Prints one line per mismatch up to a cap, and always counts.
  task automatic report_error(input string msg);
    errors++;
    if (errors <= MaxPrinted) $display("%0t ns: ERROR %s", $time, msg);
  endtask

  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Writes one register once every owed result has left the block. Bits of
  // the word above the register's width carry random junk, which the block
  // must ignore. Valid is lowered before the next write can start.
  task automatic write_register(input reg_index_t idx, input int value);
    cfg_data_t word;
    case (idx)
      REG_MODE:        word = {15'($urandom), value[1:0]};
      REG_FRAME_COUNT: word = cfg_data_t'(value);
      default:         word = {9'($urandom), value[7:0]};
    endcase
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= word;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    apply_register(idx, word);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one pixel and waits for its transfer. With more set the caller
  // offers the next pixel in the same cycle, so valid stays high; otherwise
  // valid falls and the caller waits before it offers the next pixel.
  task automatic send_pixel(input pixel_t px, input bit more, input bit checked,
                            input limited_pixel_t want);
    limited_pixel_t res;
    pix_in.valid        <= 1'b1;
    pix_in.frame_start  <= px.frame_start;
    pix_in.luma_in      <= px.luma;
    pix_in.blue_diff_in <= px.blue_diff;
    pix_in.red_diff_in  <= px.red_diff;
    do @(posedge clk); while (pix_in.ready !== 1'b1);
    // The predictor runs for every pixel so that the frame state follows.
    res = limit_pixel(px);
    expected_pixels.push_back(checked ? want : res);
    if (!more) pix_in.valid <= 1'b0;
  endtask

  // Random sample biased toward the current legal range and its edges.
  function automatic sample_t pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom_range(int'(level_low), int'(level_high));
      3:       v = int'(level_low) + $urandom_range(0, 2) - 1;
      4:       v = int'(level_high) + $urandom_range(0, 2) - 1;
      5:       v = $urandom_range(0, 1) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return sample_t'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------

  // Every transfer on the output is compared with the oldest owed result.
  always @(posedge clk) begin
    if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      observed = '{pix_out.luma_out, pix_out.blue_diff_out, pix_out.red_diff_out,
                   pix_out.out_of_range, pix_out.filter_active};
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("result %0d/%0d/%0d with none owed",
                               observed.luma, observed.blue_diff, observed.red_diff));
      end else begin
        predicted = expected_pixels.pop_front();
        if (observed !== predicted) begin
          report_error($sformatf(
            "got Y %0d Cb %0d Cr %0d oor %0b act %0b, want Y %0d Cb %0d Cr %0d oor %0b act %0b",
            observed.luma, observed.blue_diff, observed.red_diff,
            observed.out_of_range, observed.filter_active,
            predicted.luma, predicted.blue_diff, predicted.red_diff,
            predicted.out_of_range, predicted.filter_active));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------

  // The receiver stalls in styles that change after random spans:
  // always ready, mostly ready, coin flip, and short ready windows. A hold
  // request from the sender makes it refuse every transfer for a long
  // stretch, so the pipeline fills and backs up into the input.
  initial begin
    int style;
    int span;
    int served;
    style = 0;
    span = 0;
    served = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served++;
        pix_out.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(10, 60);
        end
        span--;
        case (style)
          0:       pix_out.ready <= 1'b1;
          1:       pix_out.ready <= ($urandom_range(0, 3) != 0);
          2:       pix_out.ready <= 1'($urandom_range(0, 1));
          default: pix_out.ready <= ((span % 8) < 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------

  // Counts cycles in which no channel moves a transfer.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
          (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    int     sent;
    int     segment;
    int     frames;
    int     frame_len;
    int     burst_left;
    int     gap;
    int     pick;
    int     lo;
    int     hi;
    bit     press;
    bit     last;
    bit     more;
    pixel_t px;

    errors        = 0;
    hold_requests = 0;
    sent          = 0;
    segment       = 0;
    burst_left    = 0;

    // Reset values of the registers and of the frame state.
    set_mode     = MODE_CLIP;
    level_low    = LowLevelInit;
    level_high   = HighLevelInit;
    frames_to_go = CountLocked;
    frame_on     = 1'b0;

    // Every input is at a known value before the first edge.
    rst                 <= 1'b1;
    pix_in.valid        <= 1'b0;
    pix_in.frame_start  <= 1'b0;
    pix_in.luma_in      <= '0;
    pix_in.blue_diff_in <= '0;
    pix_in.red_diff_in  <= '0;
    cfg.valid           <= 1'b0;
    cfg.index           <= REG_MODE;
    cfg.data            <= '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table. Consecutive pixel rows go back to back.
    for (int i = 0; i < NumRows; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        more = (i + 1 < NumRows) && (directed_rows[i + 1].kind == ROW_PIXEL);
        send_pixel(directed_rows[i].px, more, directed_rows[i].checked,
                   directed_rows[i].want);
        if (!more) @(posedge clk);
      end
    end

    // Random part: segments of whole frames, each under fresh settings.
    while (sent < RandomPixels) begin
      // New settings are written with the pipeline empty. The mode is
      // always rewritten; the spare mode turns up now and then.
      pick = $urandom_range(0, 9);
      write_register(REG_MODE, pick < 3 ? MODE_CLIP : pick < 6 ? MODE_SCALE :
                               pick < 9 ? MODE_DETECT : MODE_SPARE);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       pick = -1;
          1:       pick = 0;
          2, 3:    pick = $urandom_range(1, 4);
          4:       pick = 65535;
          5:       pick = -int'($urandom_range(1, 65536));
          default: pick = $urandom_range(5, 65535);
        endcase
        write_register(REG_FRAME_COUNT, pick);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0: begin lo = 16; hi = 235; end
          1: begin lo = 0; hi = 255; end
          2: begin lo = $urandom_range(0, 127); hi = $urandom_range(128, 255); end
          3: begin lo = $urandom_range(128, 255); hi = $urandom_range(0, 127); end
          4: begin lo = $urandom_range(0, 255); hi = lo; end
          default: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); end
        endcase
        write_register(REG_LOW_LEVEL, lo);
        write_register(REG_HIGH_LEVEL, hi);
      end

      // A pressure segment asks the receiver for its long hold-off and then
      // offers pixels without gaps, so the block fills and refuses input.
      press = (segment == 2) || ($urandom_range(0, 15) == 0);
      if (press) hold_requests <= hold_requests + 1;

      frames = $urandom_range(1, 5);
      for (int f = 0; f < frames; f++) begin
        frame_len = press ? $urandom_range(10, 16) : $urandom_range(2, 16);
        for (int p = 0; p < frame_len; p++) begin
          // Mostly a frame start on the first pixel only; a stray mark
          // inside a frame cuts it short.
          px.frame_start = (p == 0) || ($urandom_range(0, 39) == 0);
          px.luma        = pick_sample();
          px.blue_diff   = pick_sample();
          px.red_diff    = pick_sample();
          last = (f == frames - 1) && (p == frame_len - 1);
          if (last) begin
            gap = 1;
          end else if (press || burst_left > 0) begin
            if (burst_left > 0) burst_left--;
            gap = 0;
          end else begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(0, 25);
          end
          send_pixel(px, gap == 0, 1'b0, '0);
          sent++;
          repeat (gap) @(posedge clk);
        end
      end
      segment++;
    end

    // Let every owed result arrive, then give the block a settling pause
    // to show any stray output.
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_error($sformatf("%0d results never arrived", expected_pixels.size()));
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
